/* rtl/candle_flicker_intensity_top_assert.svh */
// assertion helpers for the candle flicker intensity block
`ifndef CANDLE_FLICKER_INTENSITY_TOP_ASSERT_SVH
`define CANDLE_FLICKER_INTENSITY_TOP_ASSERT_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define CFI_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("cfi check failed");

// next-cycle implication, sampled on clk_i, off while rst_ni is low
`define CFI_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("cfi check failed");

`endif

/* rtl/cfi_pkg.sv */
package cfi_pkg;

  // field widths
  localparam int NoiseW   = 4;
  localparam int WordW    = 16;
  localparam int FlenW    = 2;
  localparam int ClenW    = 4;
  localparam int GateW    = 2;
  localparam int BlenW    = 2;
  localparam int BrightW  = 8;
  localparam int PhaseW   = 2;
  localparam int LevelW   = 3;

  // internal widths
  localparam int PtW      = 7;
  localparam int BtW      = 3;
  localparam int SpanW    = 5;
  localparam int ExtraW   = 6;
  localparam int SineW    = 10;
  localparam int DivisorW = 9;
  localparam int CntW     = $clog2(WordW + 1);
  localparam int NumW     = SpanW + PtW;

  localparam int DampTicks = 75;
  localparam logic [LevelW-1:0] FlashLevelRst = 3'd4;

  // phase codes
  localparam logic [PhaseW-1:0] PH_NORMAL = 2'd0;
  localparam logic [PhaseW-1:0] PH_FLASH  = 2'd1;
  localparam logic [PhaseW-1:0] PH_CHAOS  = 2'd2;
  localparam logic [PhaseW-1:0] PH_DAMP   = 2'd3;

  typedef struct packed {
    logic [NoiseW-1:0] noise;
    logic [WordW-1:0]  flash_word;
    logic [FlenW-1:0]  flash_len_pick;
    logic [ClenW-1:0]  chaos_len_pick;
    logic [GateW-1:0]  burst_gate;
    logic [BlenW-1:0]  burst_len_pick;
  } item_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  typedef struct packed {
    logic [WordW-1:0]    quotient;
    logic [DivisorW-1:0] remainder;
  } div_res_t;

  typedef logic [(1<<NoiseW)-1:0][BrightW-1:0]  lvl_tab_t;
  typedef logic [(1<<PtW)-1:0][SineW-1:0]       sine_tab_t;
  typedef logic [(1<<LevelW)-1:0][DivisorW-1:0] dvsr_tab_t;

  // sine recurrence constants, q30
  localparam longint Q30One  = 64'sd1073741824;
  localparam longint Q30Half = 64'sd536870912;
  localparam longint K2Cos1  = 64'sd1160290367;
  localparam longint Sin1Q30 = 64'sd903522590;
  localparam longint Q22One  = 64'sd4194304;
  localparam longint Q22Half = 64'sd2097152;

  function automatic longint round_q30(longint v);
    if (v >= 0) begin
      return (v + Q30Half) / Q30One;
    end
    return -((-v + Q30Half) / Q30One);
  endfunction

  function automatic longint round_q22(longint v);
    if (v >= 0) begin
      return (v + Q22Half) / Q22One;
    end
    return -((-v + Q22Half) / Q22One);
  endfunction

  // q8 sine of the integer angle, two's complement
  function automatic sine_tab_t build_sine();
    sine_tab_t t;
    longint prev;
    longint cur;
    longint nxt;
    t    = '0;
    prev = 0;
    cur  = Sin1Q30;
    for (int i = 1; i < (1 << PtW); i++) begin
      t[i] = SineW'(round_q22(cur));
      nxt  = round_q30(K2Cos1 * cur) - prev;
      prev = cur;
      cur  = nxt;
    end
    return t;
  endfunction

  // floor(base*4/5) with base = 255 - noise
  function automatic lvl_tab_t build_low();
    lvl_tab_t t;
    int b;
    for (int n = 0; n < (1 << NoiseW); n++) begin
      b    = 255 - n;
      t[n] = BrightW'((b * 4) / 5);
    end
    return t;
  endfunction

  // floor(base*9/10)
  function automatic lvl_tab_t build_mid();
    lvl_tab_t t;
    int b;
    for (int n = 0; n < (1 << NoiseW); n++) begin
      b    = 255 - n;
      t[n] = BrightW'((b * 9) / 10);
    end
    return t;
  endfunction

  // flash divisor (8 - level) * 50
  function automatic dvsr_tab_t build_dvsr();
    dvsr_tab_t t;
    for (int l = 0; l < (1 << LevelW); l++) begin
      t[l] = DivisorW'((8 - l) * 50);
    end
    return t;
  endfunction

  localparam sine_tab_t SineQ8  = build_sine();
  localparam lvl_tab_t  LowTab  = build_low();
  localparam lvl_tab_t  MidTab  = build_mid();
  localparam dvsr_tab_t DvsrTab = build_dvsr();

endpackage

/* rtl/cfi_if.sv */
interface cfi_in_if;
  logic                          valid;
  logic                          ready;
  logic [cfi_pkg::NoiseW-1:0]    noise;
  logic [cfi_pkg::WordW-1:0]     flash_word;
  logic [cfi_pkg::FlenW-1:0]     flash_len_pick;
  logic [cfi_pkg::ClenW-1:0]     chaos_len_pick;
  logic [cfi_pkg::GateW-1:0]     burst_gate;
  logic [cfi_pkg::BlenW-1:0]     burst_len_pick;

  modport source (
    output valid, noise, flash_word, flash_len_pick, chaos_len_pick, burst_gate,
           burst_len_pick,
    input  ready
  );
  modport sink (
    input  valid, noise, flash_word, flash_len_pick, chaos_len_pick, burst_gate,
           burst_len_pick,
    output ready
  );
endinterface

interface cfi_out_if;
  logic                         valid;
  logic                         ready;
  logic [cfi_pkg::BrightW-1:0]  brightness;
  logic [cfi_pkg::PhaseW-1:0]   phase;

  modport source (output valid, brightness, phase, input ready);
  modport sink (input valid, brightness, phase, output ready);
endinterface

/* rtl/cfi_sdiv.sv */
module cfi_sdiv (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [cfi_pkg::WordW-1:0]     dividend_i,
  input  logic [cfi_pkg::DivisorW-1:0]  divisor_i,
  output cfi_pkg::div_stat_t            stat_o,
  output cfi_pkg::div_res_t             res_o
);
  import cfi_pkg::*;

  logic [WordW-1:0]    sh_q;
  logic [DivisorW-1:0] rem_q;
  logic [DivisorW-1:0] dvsr_q;
  logic [CntW-1:0]     cnt_q;
  logic                done_q;

  logic [DivisorW:0]   trial;
  logic [DivisorW:0]   diff;
  logic                fits;

  // one restoring step per cycle, quotient bits shift in behind the dividend
  assign trial = {rem_q, sh_q[WordW-1]};
  assign fits  = trial >= {1'b0, dvsr_q};
  assign diff  = trial - {1'b0, dvsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else if (start_i) begin
      cnt_q  <= CntW'(WordW);
      done_q <= 1'b0;
    end else if (cnt_q != '0) begin
      cnt_q  <= cnt_q - 1'b1;
      done_q <= (cnt_q == CntW'(1));
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      sh_q   <= dividend_i;
      rem_q  <= '0;
      dvsr_q <= divisor_i;
    end else if (cnt_q != '0) begin
      sh_q  <= {sh_q[WordW-2:0], fits};
      rem_q <= fits ? diff[DivisorW-1:0] : trial[DivisorW-1:0];
    end
  end

  assign stat_o.busy      = (cnt_q != '0);
  assign stat_o.done      = done_q;
  assign res_o.quotient   = sh_q;
  assign res_o.remainder  = rem_q;

endmodule

/* rtl/cfi_phase.sv */
module cfi_phase (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  cfi_pkg::item_t              item_i,
  input  cfi_pkg::div_res_t           div_i,
  input  logic                        commit_i,
  output logic [cfi_pkg::PhaseW-1:0]  phase_o,
  output logic [cfi_pkg::PtW-1:0]     pt_dec_o,
  output logic [cfi_pkg::SpanW-1:0]   span_o,
  output logic [cfi_pkg::BrightW-1:0] bright_o,
  output logic [cfi_pkg::PhaseW-1:0]  phase_nxt_o
);
  import cfi_pkg::*;

  logic [PhaseW-1:0]  phase_q, phase_d;
  logic [PtW-1:0]     pt_q, pt_d, pt_dec;
  logic [BtW-1:0]     bt_q, bt_d, bt_dec;

  logic [BrightW-1:0] base, low, mid, bright;
  logic [ExtraW-1:0]  extra;
  logic [SineW-1:0]   wgt;
  logic [ExtraW+SineW-1:0] prod;
  logic [BrightW:0]   damp_sum;
  logic [BrightW-1:0] damp_bright;

  assign pt_dec = (pt_q != '0) ? pt_q - 1'b1 : '0;
  assign bt_dec = (bt_q != '0) ? bt_q - 1'b1 : '0;

  assign base = 8'hFF - {4'b0, item_i.noise};
  assign low  = LowTab[item_i.noise];
  assign mid  = MidTab[item_i.noise];

  // damping: low + (extra * (256 + sin)) / 256, saturating
  assign extra       = div_i.quotient[ExtraW-1:0];
  assign wgt         = SineQ8[pt_dec] + SineW'(256);
  assign prod        = {{SineW{1'b0}}, extra} * {{ExtraW{1'b0}}, wgt};
  assign damp_sum    = {1'b0, low} + {1'b0, prod[ExtraW+SineW-1:8]};
  assign damp_bright = damp_sum[BrightW] ? 8'hFF : damp_sum[BrightW-1:0];

  always_comb begin
    phase_d = phase_q;
    pt_d    = pt_dec;
    bt_d    = bt_dec;
    bright  = base;
    unique case (phase_q)
      PH_NORMAL: begin
        bright = low;
        if (pt_dec == '0 && div_i.remainder == '0) begin
          pt_d    = 7'd6 + {5'b0, item_i.flash_len_pick};
          phase_d = PH_FLASH;
        end
      end
      PH_FLASH: begin
        if (pt_dec == '0) begin
          phase_d = PH_CHAOS;
          pt_d    = 7'd10 + {3'b0, item_i.chaos_len_pick};
        end
      end
      PH_CHAOS: begin
        if (pt_dec == '0) begin
          phase_d = PH_DAMP;
          pt_d    = PtW'(DampTicks);
        end
        if (bt_dec == '0) begin
          if (item_i.burst_gate == '0) begin
            bt_d = 3'd3 + {1'b0, item_i.burst_len_pick};
          end
          bright = low;
        end else begin
          bright = mid;
        end
      end
      PH_DAMP: begin
        if (pt_dec == '0) begin
          phase_d = PH_NORMAL;
        end
        bright = damp_bright;
      end
      default: begin
        phase_d = PH_NORMAL;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_NORMAL;
      pt_q    <= '0;
      bt_q    <= '0;
    end else if (commit_i) begin
      phase_q <= phase_d;
      pt_q    <= pt_d;
      bt_q    <= bt_d;
    end
  end

  assign phase_o     = phase_q;
  assign pt_dec_o    = pt_dec;
  assign span_o      = SpanW'(mid - low);
  assign bright_o    = bright;
  assign phase_nxt_o = phase_d;

endmodule

/* rtl/candle_flicker_intensity_top.sv */
// sequence: an accepted item loads the divider, which steps one quotient bit per
//   cycle over a 16-bit dividend; the step then commits into the output register
//   once that is free, and no new item is taken before the commit
// reset: asynchronous, active low; phase normal, tick counters zero, flash level 4
// no memories, so nothing to sweep after reset
`include "candle_flicker_intensity_top_assert.svh"

module candle_flicker_intensity_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        flash_level_we_i,
  input  logic [cfi_pkg::LevelW-1:0]  flash_level_i,
  cfi_in_if.sink                      item_i,
  cfi_out_if.source                   result_o
);
  import cfi_pkg::*;

  // sequencer codes
  localparam logic [1:0] S_IDLE   = 2'd0;  // waiting for an item
  localparam logic [1:0] S_START  = 2'd1;  // load the divider
  localparam logic [1:0] S_DIV    = 2'd2;  // divider stepping
  localparam logic [1:0] S_COMMIT = 2'd3;  // update phase state, fill output

  logic [1:0]          state_q, state_d;
  logic [LevelW-1:0]   level_q;
  item_t               item_q;

  logic                accept;
  logic                commit;
  logic                div_start;
  logic                out_free;

  div_stat_t           div_stat;
  div_res_t            div_res;
  logic [WordW-1:0]    dividend;
  logic [DivisorW-1:0] divisor;
  logic [NumW-1:0]     damp_num;

  logic [PhaseW-1:0]   cur_phase;
  logic [PtW-1:0]      pt_dec;
  logic [SpanW-1:0]    span;
  logic [BrightW-1:0]  bright;
  logic [PhaseW-1:0]   phase_nxt;

  logic                out_valid_q;
  logic [BrightW-1:0]  out_bright_q;
  logic [PhaseW-1:0]   out_phase_q;

  // flash level register, to be written only while the block is idle; the block itself does not enforce this
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q <= FlashLevelRst;
    end else if (flash_level_we_i) begin
      level_q <= flash_level_i;
    end
  end

  // one item in flight; the output register lets the next item in while
  // the previous result still waits for its transfer
  assign item_i.ready = (state_q == S_IDLE);
  assign accept       = item_i.valid && item_i.ready;
  assign out_free     = !out_valid_q || result_o.ready;

  always_comb begin
    state_d   = state_q;
    div_start = 1'b0;
    commit    = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_START;
        end
      end
      S_START: begin
        div_start = 1'b1;
        state_d   = S_DIV;
      end
      S_DIV: begin
        if (div_stat.done) begin
          state_d = S_COMMIT;
        end
      end
      S_COMMIT: begin
        if (out_free) begin
          commit  = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // item fields held for the whole step
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.noise          <= item_i.noise;
      item_q.flash_word     <= item_i.flash_word;
      item_q.flash_len_pick <= item_i.flash_len_pick;
      item_q.chaos_len_pick <= item_i.chaos_len_pick;
      item_q.burst_gate     <= item_i.burst_gate;
      item_q.burst_len_pick <= item_i.burst_len_pick;
    end
  end

  // one shared division per item: in normal phase the remainder of the
  // random word by the flash divisor, in damping the quotient of
  // span * ticks by the damping length; other phases ignore the result
  assign damp_num = {{PtW{1'b0}}, span} * {{SpanW{1'b0}}, pt_dec};
  assign dividend = (cur_phase == PH_NORMAL) ? item_q.flash_word
                                             : {{(WordW-NumW){1'b0}}, damp_num};
  assign divisor  = (cur_phase == PH_NORMAL) ? DvsrTab[level_q]
                                             : DivisorW'(DampTicks);

  cfi_sdiv u_sdiv (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .divisor_i  (divisor),
    .stat_o     (div_stat),
    .res_o      (div_res)
  );

  // phase state and brightness selection
  cfi_phase u_phase (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (item_q),
    .div_i       (div_res),
    .commit_i    (commit),
    .phase_o     (cur_phase),
    .pt_dec_o    (pt_dec),
    .span_o      (span),
    .bright_o    (bright),
    .phase_nxt_o (phase_nxt)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (commit) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      out_bright_q <= bright;
      out_phase_q  <= phase_nxt;
    end
  end

  assign result_o.valid      = out_valid_q;
  assign result_o.brightness = out_bright_q;
  assign result_o.phase      = out_phase_q;

  // divider is idle whenever a new item may come in
  `CFI_ASSERT_NOW(a_ready_div_idle, item_i.ready, !div_stat.busy)
  // the divider finishes only while the sequencer waits for it
  `CFI_ASSERT_NOW(a_done_in_div, div_stat.done, state_q == S_DIV)
  // a committed step always shows up as a pending result
  `CFI_ASSERT_NEXT(a_commit_fills_out, commit, result_o.valid)

endmodule
